FILE: rtl/imt_pkg.sv
// package: request and result types, opcodes and default sizes for the injective mapping table
`timescale 1ns / 1ps
`default_nettype none

package imt_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int ID_BITS_DEF     = 16;
	localparam int FIELD_BITS      = 16;
	localparam int COUNT_BITS      = 5;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_CHECK  = 2'd1,
		OP_INSERT = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]            opcode;
		logic [1:0]            pair_count;
		logic [FIELD_BITS-1:0] key_a;
		logic [FIELD_BITS-1:0] value_a;
		logic [FIELD_BITS-1:0] key_b;
		logic [FIELD_BITS-1:0] value_b;
		logic [FIELD_BITS-1:0] key_c;
		logic [FIELD_BITS-1:0] value_c;
	} req_t;

	typedef struct packed {
		logic                  consistent;
		logic                  dropped;
		logic [COUNT_BITS-1:0] entry_count;
	} rsp_t;

endpackage

`default_nettype wire

FILE: rtl/injective_mapping_table.sv
// top level: content-addressed table holding a partial injective key to value mapping
//
// usage:
//   a request is taken at a rising edge with start high and busy low; busy is
//   always low, so a new request may be issued in every cycle
//   request.opcode selects clear, check (up to three key/value pairs against
//   the stored table) or insert (pairs added in order, existing keys kept)
//   every request gives one result: done is high for exactly one cycle while
//   result holds consistent, dropped and the entry count after the request
//   the request is registered at the accepting edge, then looked up and
//   applied at the next edge, where done and the result register are set
//   throughput: one request per cycle; all table entries are compared in
//   parallel and the table is updated at the edge where done rises, so
//   back-to-back requests see each other's effects
//   reset clears the entry count and the valid bits; key and value storage
//   are not cleared and are never read before they are written
//   the receiver cannot stall, results must be taken when done is high
`timescale 1ns / 1ps
`default_nettype none

module injective_mapping_table #(
	parameter int MAX_ENTRIES = imt_pkg::MAX_ENTRIES_DEF,
	parameter int ID_BITS     = imt_pkg::ID_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire imt_pkg::req_t request,
	output logic               done,
	output imt_pkg::rsp_t      result
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	logic [ID_BITS-1:0] key_store_q   [MAX_ENTRIES];
	logic [ID_BITS-1:0] value_store_q [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] entry_valid_q;
	logic [CNT_W-1:0]       cnt_q;

	imt_pkg::req_t req_s1;
	logic          valid_s1;

	imt_pkg::rsp_t rsp_q;
	logic          done_q;

	logic [ID_BITS-1:0] ka, va, kb, vb, kc, vc;
	logic               use_a, use_b, use_c;

	logic [MAX_ENTRIES-1:0] khit_a, khit_b, khit_c;
	logic [MAX_ENTRIES-1:0] vsame_a, vsame_b, vsame_c;
	logic [MAX_ENTRIES-1:0] vuse_a, vuse_b, vuse_c;

	logic             agree_a, agree_b, agree_c;
	logic             found_a, found_b, found_c;
	logic             store_a, store_b, store_c;
	logic             drop_a, drop_b, drop_c;
	logic [CNT_W-1:0] cnt1, cnt2, cnt3;

	logic is_clear, is_check, is_insert;

	assign busy = 1'b0;

	assign ka = ID_BITS'(req_s1.key_a);
	assign va = ID_BITS'(req_s1.value_a);
	assign kb = ID_BITS'(req_s1.key_b);
	assign vb = ID_BITS'(req_s1.value_b);
	assign kc = ID_BITS'(req_s1.key_c);
	assign vc = ID_BITS'(req_s1.value_c);

	assign use_a = (req_s1.pair_count >= 2'd1);
	assign use_b = (req_s1.pair_count >= 2'd2);
	assign use_c = (req_s1.pair_count == 2'd3);

	assign is_clear  = valid_s1 && (req_s1.opcode == imt_pkg::OP_CLEAR);
	assign is_check  = valid_s1 && (req_s1.opcode == imt_pkg::OP_CHECK);
	assign is_insert = valid_s1 && (req_s1.opcode == imt_pkg::OP_INSERT);

	// parallel compare of every entry
	always_comb begin
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			khit_a[j]  = entry_valid_q[j] && (key_store_q[j] == ka);
			khit_b[j]  = entry_valid_q[j] && (key_store_q[j] == kb);
			khit_c[j]  = entry_valid_q[j] && (key_store_q[j] == kc);
			vuse_a[j]  = entry_valid_q[j] && (value_store_q[j] == va);
			vuse_b[j]  = entry_valid_q[j] && (value_store_q[j] == vb);
			vuse_c[j]  = entry_valid_q[j] && (value_store_q[j] == vc);
			vsame_a[j] = khit_a[j] && (value_store_q[j] == va);
			vsame_b[j] = khit_b[j] && (value_store_q[j] == vb);
			vsame_c[j] = khit_c[j] && (value_store_q[j] == vc);
		end
	end

	// check: keys are unique in the table, so at most one key hit per pair
	assign agree_a = !use_a || ((|khit_a) ? (|vsame_a) : !(|vuse_a));
	assign agree_b = !use_b || ((|khit_b) ? (|vsame_b) : !(|vuse_b));
	assign agree_c = !use_c || ((|khit_c) ? (|vsame_c) : !(|vuse_c));

	// insert: pairs in order, a later pair also sees keys stored by earlier ones
	assign found_a = |khit_a;
	assign store_a = use_a && !found_a && (cnt_q < CNT_W'(MAX_ENTRIES));
	assign drop_a  = use_a && !found_a && (cnt_q >= CNT_W'(MAX_ENTRIES));
	assign cnt1    = cnt_q + CNT_W'(store_a);

	assign found_b = (|khit_b) || (store_a && (kb == ka));
	assign store_b = use_b && !found_b && (cnt1 < CNT_W'(MAX_ENTRIES));
	assign drop_b  = use_b && !found_b && (cnt1 >= CNT_W'(MAX_ENTRIES));
	assign cnt2    = cnt1 + CNT_W'(store_b);

	assign found_c = (|khit_c) || (store_a && (kc == ka)) || (store_b && (kc == kb));
	assign store_c = use_c && !found_c && (cnt2 < CNT_W'(MAX_ENTRIES));
	assign drop_c  = use_c && !found_c && (cnt2 >= CNT_W'(MAX_ENTRIES));
	assign cnt3    = cnt2 + CNT_W'(store_c);

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= request;
		end
	end

	// table storage, written in slot order
	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			if (is_insert) begin
				if (store_a && (CNT_W'(j) == cnt_q)) begin
					key_store_q[j]   <= ka;
					value_store_q[j] <= va;
				end else if (store_b && (CNT_W'(j) == cnt1)) begin
					key_store_q[j]   <= kb;
					value_store_q[j] <= vb;
				end else if (store_c && (CNT_W'(j) == cnt2)) begin
					key_store_q[j]   <= kc;
					value_store_q[j] <= vc;
				end
			end
		end
	end

	// valid bits, count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			cnt_q         <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (is_clear) begin
				entry_valid_q <= '0;
				cnt_q         <= '0;
			end else if (is_insert) begin
				for (int j = 0; j < MAX_ENTRIES; j++) begin
					if ((store_a && (CNT_W'(j) == cnt_q)) ||
					    (store_b && (CNT_W'(j) == cnt1)) ||
					    (store_c && (CNT_W'(j) == cnt2))) begin
						entry_valid_q[j] <= 1'b1;
					end
				end
				cnt_q <= cnt3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q.consistent <= is_check && agree_a && agree_b && agree_c;
			rsp_q.dropped    <= is_insert && (drop_a || drop_b || drop_c);
			if (is_clear) begin
				rsp_q.entry_count <= '0;
			end else if (is_insert) begin
				rsp_q.entry_count <= imt_pkg::COUNT_BITS'(cnt3);
			end else begin
				rsp_q.entry_count <= imt_pkg::COUNT_BITS'(cnt_q);
			end
		end
	end

	assign done   = done_q;
	assign result = rsp_q;

	// every registered request gives a result on the next cycle
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("request without result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count above table size");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(entry_valid_q) == int'(cnt_q))
		else $error("valid bits disagree with entry count");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.consistent && result.dropped))
		else $error("consistent and dropped both set");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		is_clear |=> (cnt_q == '0) && (entry_valid_q == '0))
		else $error("clear left entries behind");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// testbench: directed and random requests against the mapping table, checked by a local predictor
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

	localparam int TABLE_SLOTS = imt_pkg::MAX_ENTRIES_DEF;
	localparam int FB = imt_pkg::FIELD_BITS;
	localparam int POOL_SIZE = 24;
	localparam int ITEMS_PER_PHASE = 350;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		imt_pkg::req_t  req;
		bit             typed;
		logic           c;
		logic           d;
		logic [4:0]     n;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	imt_pkg::req_t request;
	logic done;
	imt_pkg::rsp_t result;

	logic [FB-1:0] tbl_key [TABLE_SLOTS];
	logic [FB-1:0] tbl_val [TABLE_SLOTS];
	int fill;

	logic [FB-1:0] key_pool [POOL_SIZE];
	logic [FB-1:0] val_pool [POOL_SIZE];

	imt_pkg::rsp_t pending_q [$];
	dir_row_t dir_rows [$];
	imt_pkg::rsp_t want;
	int errors;
	int cycles;
	int results_seen;
	int consistent_seen;
	int dropped_seen;
	int full_seen;
	int op_seen [4];

	injective_mapping_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, pending_q.size());
			$display("tb_top NOT OK");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (pending_q.size() == 0) begin
				$error("result with no request pending: %p", result);
				errors++;
			end else begin
				want = pending_q.pop_front();
				if (result.consistent !== want.consistent) begin
					$error("consistent: expected %0d, actual %0d", want.consistent,
						result.consistent);
					errors++;
				end
				if (result.dropped !== want.dropped) begin
					$error("dropped: expected %0d, actual %0d", want.dropped, result.dropped);
					errors++;
				end
				if (result.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, actual %0d", want.entry_count,
						result.entry_count);
					errors++;
				end
				if (want.consistent) consistent_seen++;
				if (want.dropped) dropped_seen++;
				if (want.entry_count == TABLE_SLOTS) full_seen++;
			end
		end
	end

	function automatic int find_slot(logic [FB-1:0] k);
		for (int i = 0; i < fill; i++)
			if (tbl_key[i] == k) return i;
		return -1;
	endfunction

	// applies one request to the local table copy and returns its result
	function automatic imt_pkg::rsp_t model_request(imt_pkg::req_t r);
		logic [FB-1:0] k [3];
		logic [FB-1:0] v [3];
		imt_pkg::rsp_t o;
		int slot;
		bit used;
		o = '0;
		k[0] = r.key_a; v[0] = r.value_a;
		k[1] = r.key_b; v[1] = r.value_b;
		k[2] = r.key_c; v[2] = r.value_c;
		if (r.opcode == imt_pkg::OP_CLEAR) begin
			fill = 0;
		end else if (r.opcode == imt_pkg::OP_CHECK) begin
			o.consistent = 1'b1;
			for (int i = 0; i < r.pair_count; i++) begin
				slot = find_slot(k[i]);
				if (slot >= 0) begin
					if (tbl_val[slot] != v[i]) o.consistent = 1'b0;
				end else begin
					used = 0;
					for (int j = 0; j < fill; j++)
						if (tbl_val[j] == v[i]) used = 1;
					if (used) o.consistent = 1'b0;
				end
			end
		end else if (r.opcode == imt_pkg::OP_INSERT) begin
			for (int i = 0; i < r.pair_count; i++) begin
				if (find_slot(k[i]) < 0) begin
					if (fill >= TABLE_SLOTS) begin
						o.dropped = 1'b1;
					end else begin
						tbl_key[fill] = k[i];
						tbl_val[fill] = v[i];
						fill++;
					end
				end
			end
		end
		o.entry_count = 5'(fill);
		return o;
	endfunction

	function automatic imt_pkg::req_t mk_req(logic [1:0] op, logic [1:0] cnt,
		logic [FB-1:0] ka, logic [FB-1:0] va,
		logic [FB-1:0] kb, logic [FB-1:0] vb,
		logic [FB-1:0] kc, logic [FB-1:0] vc);
		imt_pkg::req_t r;
		r.opcode = op;
		r.pair_count = cnt;
		r.key_a = ka; r.value_a = va;
		r.key_b = kb; r.value_b = vb;
		r.key_c = kc; r.value_c = vc;
		return r;
	endfunction

	function automatic dir_row_t dir_row(imt_pkg::req_t r, bit typed, logic c = 1'b0,
		logic d = 1'b0, logic [4:0] n = 5'd0);
		dir_row_t w;
		w.req = r;
		w.typed = typed;
		w.c = c;
		w.d = d;
		w.n = n;
		return w;
	endfunction

	function automatic void add_row(dir_row_t w);
		dir_rows.insert(dir_rows.size(), w);
	endfunction

	function automatic logic [FB-1:0] pick_id(bit from_vals);
		if ($urandom_range(0, 99) < 12) return FB'($urandom);
		return from_vals ? val_pool[$urandom_range(0, POOL_SIZE - 1)]
			: key_pool[$urandom_range(0, POOL_SIZE - 1)];
	endfunction

	// mostly well-formed checks and inserts over a small id pool, so the table fills and hits
	function automatic imt_pkg::req_t random_request();
		imt_pkg::req_t r;
		logic [FB-1:0] k [3];
		logic [FB-1:0] v [3];
		int sel;
		int s;
		sel = $urandom_range(0, 99);
		if (sel < 3) r.opcode = imt_pkg::OP_CLEAR;
		else if (sel < 6) r.opcode = OP_UNUSED;
		else if (sel < 50) r.opcode = imt_pkg::OP_CHECK;
		else r.opcode = imt_pkg::OP_INSERT;
		r.pair_count = ($urandom_range(0, 99) < 4) ? 2'd0 : 2'($urandom_range(1, 3));
		for (int i = 0; i < 3; i++) begin
			if (i >= r.pair_count) begin
				k[i] = FB'($urandom);
				v[i] = FB'($urandom);
			end else if (r.opcode == imt_pkg::OP_CHECK && fill > 0 &&
				$urandom_range(0, 99) < 50) begin
				s = $urandom_range(0, fill - 1);
				k[i] = tbl_key[s];
				v[i] = ($urandom_range(0, 99) < 80) ? tbl_val[s] : pick_id(1);
			end else begin
				k[i] = pick_id(0);
				v[i] = pick_id(1);
			end
		end
		r.key_a = k[0]; r.value_a = v[0];
		r.key_b = k[1]; r.value_b = v[1];
		r.key_c = k[2]; r.value_c = v[2];
		return r;
	endfunction

	task automatic send_request(input imt_pkg::req_t r, input int idle_pct, input bit typed,
		input imt_pkg::rsp_t typed_rsp);
		bit taken;
		imt_pkg::rsp_t p;
		while (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		request <= r;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		p = model_request(r);
		op_seen[r.opcode]++;
		pending_q.insert(pending_q.size(), typed ? typed_rsp : p);
	endtask

	task automatic wait_drained();
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		int idle_pct [4];
		imt_pkg::rsp_t t;
		errors = 0;
		cycles = 0;
		fill = 0;
		results_seen = 0;
		consistent_seen = 0;
		dropped_seen = 0;
		full_seen = 0;
		op_seen = '{default: 0};
		idle_pct = '{0, 78, 0, 23};
		arst_n = 1'b0;
		start <= 1'b0;
		request <= '0;

		// empty table, extremes, skipped keys, in-use values, full table
		add_row(dir_row(mk_req(imt_pkg::OP_CHECK, 2'd0, 16'h1111, 16'h2222, 16'h3333,
			16'h4444, 16'h5555, 16'h6666), 1, 1'b1, 1'b0, 5'd0));
		add_row(dir_row(mk_req(imt_pkg::OP_CHECK, 2'd3, 16'h0000, 16'h0000, 16'hffff,
			16'hffff, 16'h1234, 16'h0000), 1, 1'b1, 1'b0, 5'd0));
		add_row(dir_row(mk_req(imt_pkg::OP_INSERT, 2'd1, 16'hffff, 16'hffff, 16'h0001,
			16'h0002, 16'h0003, 16'h0004), 1, 1'b0, 1'b0, 5'd1));
		add_row(dir_row(mk_req(imt_pkg::OP_INSERT, 2'd2, 16'h0000, 16'h0000, 16'hffff,
			16'h0001, 16'h0003, 16'h0004), 1, 1'b0, 1'b0, 5'd2));
		add_row(dir_row(mk_req(imt_pkg::OP_CHECK, 2'd1, 16'hffff, 16'h0001, 16'h0000,
			16'h0000, 16'h0000, 16'h0000), 1, 1'b0, 1'b0, 5'd2));
		add_row(dir_row(mk_req(imt_pkg::OP_CHECK, 2'd2, 16'hffff, 16'hffff, 16'h0000,
			16'h0000, 16'h0000, 16'hffff), 1, 1'b1, 1'b0, 5'd2));
		add_row(dir_row(mk_req(imt_pkg::OP_CHECK, 2'd1, 16'h0005, 16'hffff, 16'h0000,
			16'h0000, 16'h0000, 16'h0000), 1, 1'b0, 1'b0, 5'd2));
		// pairs of one check are not compared with each other
		add_row(dir_row(mk_req(imt_pkg::OP_CHECK, 2'd3, 16'h0009, 16'h0009, 16'h0009,
			16'h000a, 16'h0000, 16'h0000), 1, 1'b1, 1'b0, 5'd2));
		// repeated key in one insert: first one wins
		add_row(dir_row(mk_req(imt_pkg::OP_INSERT, 2'd2, 16'h0007, 16'h0001, 16'h0007,
			16'h0002, 16'h0000, 16'h0000), 1, 1'b0, 1'b0, 5'd3));
		add_row(dir_row(mk_req(imt_pkg::OP_CHECK, 2'd1, 16'h0007, 16'h0001, 16'h0007,
			16'h0002, 16'h0000, 16'h0000), 0));
		add_row(dir_row(mk_req(imt_pkg::OP_INSERT, 2'd0, 16'h0aaa, 16'h0bbb, 16'h0ccc,
			16'h0ddd, 16'h0eee, 16'h0fff), 1, 1'b0, 1'b0, 5'd3));
		add_row(dir_row(mk_req(OP_UNUSED, 2'd3, 16'hffff, 16'h0000, 16'h0abc,
			16'h0def, 16'hffff, 16'hffff), 1, 1'b0, 1'b0, 5'd3));
		for (int i = 0; i < 5; i++)
			add_row(dir_row(mk_req(imt_pkg::OP_INSERT, 2'd3, 16'h0100 + 16'(3 * i),
				16'h8000 + 16'(3 * i), 16'h0101 + 16'(3 * i), 16'h8001 + 16'(3 * i),
				16'h0102 + 16'(3 * i), 16'h8002 + 16'(3 * i)), i == 4, 1'b0, 1'b1, 5'd16));
		// existing keys are still fine at full table
		add_row(dir_row(mk_req(imt_pkg::OP_INSERT, 2'd3, 16'hffff, 16'h1234, 16'h0000,
			16'h5678, 16'h0007, 16'h9abc), 1, 1'b0, 1'b0, 5'd16));
		add_row(dir_row(mk_req(imt_pkg::OP_CHECK, 2'd3, 16'h0105, 16'h8005, 16'h010e,
			16'h800e, 16'h0110, 16'h8010), 0));
		add_row(dir_row(mk_req(imt_pkg::OP_CLEAR, 2'd3, 16'hffff, 16'hffff, 16'hffff,
			16'hffff, 16'hffff, 16'hffff), 1, 1'b0, 1'b0, 5'd0));
		add_row(dir_row(mk_req(imt_pkg::OP_CHECK, 2'd1, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000), 1, 1'b1, 1'b0, 5'd0));
		add_row(dir_row(mk_req(imt_pkg::OP_INSERT, 2'd3, 16'h5555, 16'haaaa, 16'haaaa,
			16'h5555, 16'h5555, 16'h0000), 0));
		add_row(dir_row(mk_req(imt_pkg::OP_CHECK, 2'd3, 16'haaaa, 16'h5555, 16'h5555,
			16'h5555, 16'h1234, 16'haaaa), 0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			t.consistent = dir_rows[i].c;
			t.dropped = dir_rows[i].d;
			t.entry_count = dir_rows[i].n;
			send_request(dir_rows[i].req, 0, dir_rows[i].typed, t);
		end

		for (int ph = 0; ph < 4; ph++) begin
			key_pool[0] = 16'h0000;
			key_pool[1] = 16'hffff;
			val_pool[0] = 16'h0000;
			val_pool[1] = 16'hffff;
			for (int i = 2; i < POOL_SIZE; i++) begin
				key_pool[i] = FB'($urandom);
				val_pool[i] = FB'($urandom);
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_request(random_request(), idle_pct[ph], 0, '0);
			start <= 1'b0;
			wait_drained();
			@(posedge clk);
		end

		repeat (6) @(posedge clk);
		if (pending_q.size() != 0) begin
			$error("%0d results never arrived", pending_q.size());
			errors++;
		end
		$display("requests: %0d clear, %0d check, %0d insert, %0d unused opcode; %0d results",
			op_seen[imt_pkg::OP_CLEAR], op_seen[imt_pkg::OP_CHECK],
			op_seen[imt_pkg::OP_INSERT], op_seen[OP_UNUSED], results_seen);
		$display("%0d consistent checks, %0d inserts dropped pairs, %0d results at full table",
			consistent_seen, dropped_seen, full_seen);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
